/* rtl/odo_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// odo_pkg
// Shared widths, fixed-point constants and the CORDIC arc table for the
// differential-drive odometry block.
// ============================================================================
package odo_pkg;

  // Default number of CORDIC micro-rotations.
  localparam int CORDIC_STEPS_DEF = 18;

  // Serial multiplier: parallel operand and product width, serial operand width.
  localparam int MUL_AW = 64;
  localparam int MUL_BW = 34;

  // Serial divider: dividend and divisor widths.
  localparam int DIV_NW = 55;
  localparam int DIV_DW = 33;

  // CORDIC angle and vector width (Q2.30 with headroom).
  localparam int ANG_W = 34;

  // Input action codes.
  localparam logic [1:0] ACT_LEFT  = 2'd0;
  localparam logic [1:0] ACT_RIGHT = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_MPC = 1'b0;
  localparam logic REG_IWB = 1'b1;

  localparam logic [31:0] MPC_RESET = 32'd318584;
  localparam logic [23:0] IWB_RESET = 24'd668734;

  // Angle constants.
  localparam logic signed [34:0] PI_Q30   = 35'sd3373259426;
  localparam logic signed [34:0] FULL_Q30 = 35'sd6746518852;
  localparam logic signed [33:0] HALF_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [34:0] PI_Q16   = 35'sd205887;
  localparam logic signed [34:0] FULL_Q16 = 35'sd411775;

  // Arctangent of 2^-i in Q2.30; past the table the small-angle value is used.
  function automatic logic signed [33:0] arc_step(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:    r = 34'sd843314857;
      5'd1:    r = 34'sd497837830;
      5'd2:    r = 34'sd263043837;
      5'd3:    r = 34'sd133525159;
      5'd4:    r = 34'sd67021687;
      5'd5:    r = 34'sd33543516;
      5'd6:    r = 34'sd16775851;
      5'd7:    r = 34'sd8388437;
      5'd8:    r = 34'sd4194283;
      5'd9:    r = 34'sd2097149;
      5'd31:   r = '0;
      default: r = 34'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

/* rtl/diff_drive_odometry.sv */
`timescale 1ns / 1ps
// ============================================================================
// diff_drive_odometry
// Wheel encoder edge counting and midpoint differential-drive odometry in
// Q16.16, built around a bit-serial multiplier, a bit-serial divider and an
// iterative CORDIC, each shared by the steps of a tick that use it.
// ============================================================================
//
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_ready  action, phase_b, elapsed_ms
// out      source     out_valid/out_ready  pose, heading, quaternion, speeds
// cfg      sink       cfg_we               cfg_index, cfg_data
//
// An encoder edge is counted while the block is idle. A tick runs through the
// 34-bit serial multiplier, the 55-bit serial divider and the CORDIC; with zero
// elapsed time the two speed divisions are skipped.
// Reset clears the counters, the pose and the output valid flag, and loads the
// register reset values. The result sits in an output register, so the block
// takes edges while a finished transaction waits; a new tick completes only
// once that register is free.
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic               phase_b,
  input  logic [15:0]        elapsed_ms,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [18:0] heading,
  output logic signed [17:0] quat_w,
  output logic signed [17:0] quat_z,
  output logic signed [31:0] linear_speed,
  output logic signed [31:0] turn_rate,
  output logic               zero_interval
);

  typedef enum logic [3:0] {
    IDLE, MUL_SUM, MUL_DIF, MUL_TURN, DIV_MID, COR_MID, MUL_X, MUL_Y,
    DIV_HEAD, COR_HEAD, DIV_LIN, DIV_ANG, FINISH
  } state_t;

  state_t state;
  logic   go;

  // Configuration registers.
  logic [31:0] metres_per_count;
  logic [23:0] inverse_wheel_base;

  // Odometry state.
  logic signed [15:0] left_delta;
  logic signed [15:0] right_delta;
  logic signed [31:0] pose_x_acc;
  logic signed [31:0] pose_y_acc;
  logic signed [18:0] heading_acc;

  // Per-tick working registers.
  logic        [15:0] ms_q;
  logic signed [33:0] d_q;
  logic signed [33:0] diff_q;
  logic signed [41:0] dth_q;
  logic signed [33:0] mid_q;
  logic signed [31:0] lin_q;
  logic signed [31:0] ang_q;

  // Shared units.
  logic                                mul_start;
  logic                                mul_done;
  logic signed [odo_pkg::MUL_AW-1:0]   mul_a;
  logic signed [odo_pkg::MUL_BW-1:0]   mul_b;
  logic signed [odo_pkg::MUL_AW-1:0]   mul_p;
  logic                                div_start;
  logic                                div_done;
  logic        [odo_pkg::DIV_NW-1:0]   div_num;
  logic        [odo_pkg::DIV_DW-1:0]   div_den;
  logic                                div_neg;
  logic        [odo_pkg::DIV_NW-1:0]   div_quo;
  logic        [odo_pkg::DIV_DW-1:0]   div_rem;
  logic                                cor_start;
  logic                                cor_done;
  logic signed [odo_pkg::ANG_W-1:0]    cor_angle;
  logic signed [odo_pkg::ANG_W-1:0]    cor_cos;
  logic signed [odo_pkg::ANG_W-1:0]    cor_sin;

  // Datapath around the units.
  logic signed [16:0] sum_lr;
  logic signed [16:0] dif_rl;
  logic signed [63:0] rnd17;
  logic signed [63:0] rnd16;
  logic signed [63:0] rnd30;
  logic signed [55:0] step_x;
  logic signed [55:0] step_y;
  logic signed [55:0] mid_raw;
  logic        [55:0] mid_abs;
  logic signed [42:0] h_raw;
  logic        [42:0] h_abs;
  logic signed [45:0] d_ext;
  logic signed [45:0] num_l;
  logic        [45:0] lin_abs;
  logic signed [53:0] dth_ext;
  logic signed [53:0] num_a;
  logic        [53:0] ang_abs;
  logic signed [55:0] speed;

  function automatic logic signed [15:0] count_edge(input logic signed [15:0] c,
                                                    input logic up);
    logic signed [15:0] r;
    r = c;
    if (up) begin
      if (c != 16'sh7fff) r = c + 16'sd1;
    end else begin
      if (c != 16'sh8000) r = c - 16'sd1;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
    logic signed [31:0] r;
    if (v > 56'sd2147483647) r = 32'sh7fffffff;
    else if (v < -56'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Applies the dividend sign to a remainder and moves it into [-half, half].
  function automatic logic signed [33:0] wrap_rem(input logic neg,
                                                  input logic [32:0] rem,
                                                  input logic signed [34:0] half,
                                                  input logic signed [34:0] full);
    logic signed [34:0] r;
    r = neg ? -$signed({2'b00, rem}) : $signed({2'b00, rem});
    if (r > half) r = r - full;
    else if (r < -half) r = r + full;
    return r[33:0];
  endfunction

  function automatic logic signed [17:0] to_unit(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd8192) >>> 14;
    if (t > 34'sd65536) t = 34'sd65536;
    else if (t < -34'sd65536) t = -34'sd65536;
    return t[17:0];
  endfunction

  assign sum_lr = 17'(left_delta) + 17'(right_delta);
  assign dif_rl = 17'(right_delta) - 17'(left_delta);

  // Rounded rescales of the product.
  assign rnd17  = (mul_p + 64'sd65536) >>> 17;
  assign rnd16  = (mul_p + 64'sd32768) >>> 16;
  assign rnd30  = (mul_p + 64'sd536870912) >>> 30;
  assign step_x = $signed(rnd30[55:0]) + 56'(pose_x_acc);
  assign step_y = $signed(rnd30[55:0]) + 56'(pose_y_acc);

  // Midpoint angle in Q2.30 and the new heading in Q16.16, before wrapping.
  assign mid_raw = (56'(heading_acc) <<< 14) + (56'(dth_q) <<< 13);
  assign mid_abs = mid_raw[55] ? 56'(-mid_raw) : mid_raw;
  assign h_raw   = 43'(heading_acc) + 43'(dth_q);
  assign h_abs   = h_raw[42] ? 43'(-h_raw) : h_raw;

  // Times 1000 as 1024 - 16 - 8.
  assign d_ext   = 46'(d_q);
  assign num_l   = (d_ext <<< 10) - (d_ext <<< 4) - (d_ext <<< 3);
  assign lin_abs = num_l[45] ? 46'(-num_l) : num_l;
  assign dth_ext = 54'(dth_q);
  assign num_a   = (dth_ext <<< 10) - (dth_ext <<< 4) - (dth_ext <<< 3);
  assign ang_abs = num_a[53] ? 54'(-num_a) : num_a;

  // Quotient truncated toward zero.
  assign speed = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_num   = '0;
    div_den   = '0;
    div_neg   = 1'b0;
    cor_angle = '0;
    unique case (state)
      MUL_SUM: begin
        mul_a = $signed({32'd0, metres_per_count});
        mul_b = 34'(sum_lr);
      end
      MUL_DIF: begin
        mul_a = $signed({32'd0, metres_per_count});
        mul_b = 34'(dif_rl);
      end
      MUL_TURN: begin
        mul_a = $signed({40'd0, inverse_wheel_base});
        mul_b = diff_q;
      end
      MUL_X: begin
        mul_a = 64'(cor_cos);
        mul_b = d_q;
      end
      MUL_Y: begin
        mul_a = 64'(cor_sin);
        mul_b = d_q;
      end
      DIV_MID: begin
        div_num = mid_abs[54:0];
        div_den = odo_pkg::FULL_Q30[32:0];
        div_neg = mid_raw[55];
      end
      DIV_HEAD: begin
        div_num = {12'd0, h_abs};
        div_den = odo_pkg::FULL_Q16[32:0];
        div_neg = h_raw[42];
      end
      DIV_LIN: begin
        div_num = {9'd0, lin_abs};
        div_den = {17'd0, ms_q};
        div_neg = num_l[45];
      end
      DIV_ANG: begin
        div_num = {1'b0, ang_abs};
        div_den = {17'd0, ms_q};
        div_neg = num_a[53];
      end
      COR_MID:  cor_angle = mid_q;
      COR_HEAD: cor_angle = 34'(heading_acc) <<< 13;
      default: ;
    endcase
  end

  // A unit is launched in the first cycle of the state that uses it.
  assign mul_start = go && (state == MUL_SUM || state == MUL_DIF || state == MUL_TURN ||
                            state == MUL_X || state == MUL_Y);
  assign div_start = go && (state == DIV_MID || state == DIV_HEAD ||
                            state == DIV_LIN || state == DIV_ANG);
  assign cor_start = go && (state == COR_MID || state == COR_HEAD);

  assign in_ready = (state == IDLE);

  odo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  odo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  odo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .cos_o (cor_cos),
    .sin_o (cor_sin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= IDLE;
      go                 <= 1'b0;
      out_valid          <= 1'b0;
      metres_per_count   <= odo_pkg::MPC_RESET;
      inverse_wheel_base <= odo_pkg::IWB_RESET;
      left_delta         <= '0;
      right_delta        <= '0;
      pose_x_acc         <= '0;
      pose_y_acc         <= '0;
      heading_acc        <= '0;
    end else begin
      go <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          odo_pkg::REG_MPC: metres_per_count   <= cfg_data;
          odo_pkg::REG_IWB: inverse_wheel_base <= cfg_data[23:0];
          default: ;
        endcase
      end

      // The finish step refills the output register in the cycle it empties.
      if (out_valid && out_ready && state != FINISH) out_valid <= 1'b0;

      unique case (state)
        IDLE: begin
          if (in_valid) begin
            case (action)
              odo_pkg::ACT_LEFT:  left_delta  <= count_edge(left_delta, phase_b);
              odo_pkg::ACT_RIGHT: right_delta <= count_edge(right_delta, phase_b);
              odo_pkg::ACT_TICK: begin
                ms_q  <= elapsed_ms;
                state <= MUL_SUM;
                go    <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        MUL_SUM: begin
          if (mul_done) begin
            d_q   <= rnd17[33:0];
            state <= MUL_DIF;
            go    <= 1'b1;
          end
        end
        MUL_DIF: begin
          if (mul_done) begin
            diff_q <= rnd16[33:0];
            state  <= MUL_TURN;
            go     <= 1'b1;
          end
        end
        MUL_TURN: begin
          if (mul_done) begin
            dth_q <= rnd16[41:0];
            state <= DIV_MID;
            go    <= 1'b1;
          end
        end
        DIV_MID: begin
          if (div_done) begin
            mid_q <= wrap_rem(div_neg, div_rem, odo_pkg::PI_Q30, odo_pkg::FULL_Q30);
            state <= COR_MID;
            go    <= 1'b1;
          end
        end
        COR_MID: begin
          if (cor_done) begin
            state <= MUL_X;
            go    <= 1'b1;
          end
        end
        MUL_X: begin
          if (mul_done) begin
            pose_x_acc <= sat32(step_x);
            state      <= MUL_Y;
            go         <= 1'b1;
          end
        end
        MUL_Y: begin
          if (mul_done) begin
            pose_y_acc <= sat32(step_y);
            state      <= DIV_HEAD;
            go         <= 1'b1;
          end
        end
        DIV_HEAD: begin
          if (div_done) begin
            heading_acc <= 19'(wrap_rem(div_neg, div_rem, odo_pkg::PI_Q16,
                                        odo_pkg::FULL_Q16));
            state       <= COR_HEAD;
            go          <= 1'b1;
          end
        end
        COR_HEAD: begin
          if (cor_done) begin
            // With no elapsed time the speeds are forced to zero.
            if (ms_q == 16'd0) begin
              lin_q <= '0;
              ang_q <= '0;
              state <= FINISH;
            end else begin
              state <= DIV_LIN;
              go    <= 1'b1;
            end
          end
        end
        DIV_LIN: begin
          if (div_done) begin
            lin_q <= sat32(speed);
            state <= DIV_ANG;
            go    <= 1'b1;
          end
        end
        DIV_ANG: begin
          if (div_done) begin
            ang_q <= sat32(speed);
            state <= FINISH;
          end
        end
        FINISH: begin
          if (!out_valid || out_ready) begin
            pos_x         <= pose_x_acc;
            pos_y         <= pose_y_acc;
            heading       <= heading_acc;
            quat_w        <= to_unit(cor_cos);
            quat_z        <= to_unit(cor_sin);
            linear_speed  <= lin_q;
            turn_rate     <= ang_q;
            zero_interval <= (ms_q == 16'd0);
            out_valid     <= 1'b1;
            left_delta    <= '0;
            right_delta   <= '0;
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A tick takes the block off the input channel for its whole computation.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == odo_pkg::ACT_TICK) |=> !in_ready)
    else $error("input accepted during tick computation");

  // The stored heading never leaves [-pi, pi].
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    (heading_acc <= 19'sd205887) && (heading_acc >= -19'sd205887))
    else $error("heading out of range");

  // Zero elapsed time forces both speeds to zero.
  a_zero_speed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_interval) |-> (linear_speed == 32'sd0 && turn_rate == 32'sd0))
    else $error("speed not zero on zero interval");

  // The quaternion parts are clamped to the unit range.
  a_quat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quat_w <= 18'sd65536 && quat_w >= -18'sd65536 &&
                   quat_z <= 18'sd65536 && quat_z >= -18'sd65536))
    else $error("quaternion out of range");

endmodule

/* rtl/odo_mul.sv */
`timescale 1ns / 1ps
// ============================================================================
// odo_mul
// Bit-serial signed multiplier: one bit of the serial operand per cycle.
// ============================================================================
module odo_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [odo_pkg::MUL_AW-1:0]   a,
  input  logic signed [odo_pkg::MUL_BW-1:0]   b,
  output logic                                done,
  output logic signed [odo_pkg::MUL_AW-1:0]   prod
);

  localparam int CNTW = $clog2(odo_pkg::MUL_BW);

  logic signed [odo_pkg::MUL_AW-1:0] acc;
  logic signed [odo_pkg::MUL_AW-1:0] a_sh;
  logic        [odo_pkg::MUL_BW-1:0] b_sh;
  logic        [CNTW-1:0]            cnt;
  logic                              busy;
  logic signed [odo_pkg::MUL_AW-1:0] addend;
  logic                              last;

  assign addend = b_sh[0] ? a_sh : '0;
  assign last   = (cnt == CNTW'(odo_pkg::MUL_BW - 1));
  assign prod   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= '0;
        a_sh <= a;
        b_sh <= b;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        // The sign bit of the serial operand carries negative weight.
        acc  <= last ? acc - addend : acc + addend;
        a_sh <= a_sh <<< 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/odo_div.sv */
`timescale 1ns / 1ps
// ============================================================================
// odo_div
// Restoring unsigned divider: one quotient bit per cycle.
// ============================================================================
module odo_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [odo_pkg::DIV_NW-1:0]    num,
  input  logic [odo_pkg::DIV_DW-1:0]    den,
  output logic                          done,
  output logic [odo_pkg::DIV_NW-1:0]    quo,
  output logic [odo_pkg::DIV_DW-1:0]    rem
);

  localparam int CNTW = $clog2(odo_pkg::DIV_NW);

  logic [odo_pkg::DIV_NW-1:0] n_sh;
  logic [odo_pkg::DIV_DW-1:0] r;
  logic [odo_pkg::DIV_DW-1:0] den_q;
  logic [CNTW-1:0]            cnt;
  logic                       busy;
  logic [odo_pkg::DIV_DW:0]   trial;
  logic [odo_pkg::DIV_DW:0]   diff;
  logic                       fits;

  assign trial = {r, n_sh[odo_pkg::DIV_NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});
  assign quo   = n_sh;
  assign rem   = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n_sh  <= num;
        r     <= '0;
        den_q <= den;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        r    <= fits ? diff[odo_pkg::DIV_DW-1:0] : trial[odo_pkg::DIV_DW-1:0];
        n_sh <= {n_sh[odo_pkg::DIV_NW-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == CNTW'(odo_pkg::DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/odo_cordic.sv */
`timescale 1ns / 1ps
// ============================================================================
// odo_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q2.30.
// ============================================================================
module odo_cordic #(
  parameter int STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [odo_pkg::ANG_W-1:0]   angle,
  output logic                               done,
  output logic signed [odo_pkg::ANG_W-1:0]   cos_o,
  output logic signed [odo_pkg::ANG_W-1:0]   sin_o
);

  localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic signed [odo_pkg::ANG_W-1:0] PI_A =
    $signed(odo_pkg::PI_Q30[odo_pkg::ANG_W-1:0]);

  logic signed [odo_pkg::ANG_W-1:0] x;
  logic signed [odo_pkg::ANG_W-1:0] y;
  logic signed [odo_pkg::ANG_W-1:0] z;
  logic signed [odo_pkg::ANG_W-1:0] xs;
  logic signed [odo_pkg::ANG_W-1:0] ys;
  logic signed [odo_pkg::ANG_W-1:0] arc;
  logic        [CW-1:0]             iter;
  logic                             busy;
  logic                             flip;

  assign xs    = x >>> iter;
  assign ys    = y >>> iter;
  assign arc   = odo_pkg::arc_step(5'(iter));
  assign cos_o = flip ? -x : x;
  assign sin_o = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // Fold into the right half plane; the results are negated at the end.
        if (angle > odo_pkg::HALF_Q30) begin
          z    <= angle - PI_A;
          flip <= 1'b1;
        end else if (angle < -odo_pkg::HALF_Q30) begin
          z    <= angle + PI_A;
          flip <= 1'b1;
        end else begin
          z    <= angle;
          flip <= 1'b0;
        end
        x    <= odo_pkg::GAIN_Q30;
        y    <= '0;
        iter <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - arc;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + arc;
        end
        iter <= iter + 1'b1;
        if (iter == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
